// File: hw/rtl/utc_to_cet_local_time_macros.svh
// assertion macros for the utc to cet/cest local time converter
// expects clk and rst_n in the scope of the use; no other dependencies
`ifndef UTC_TO_CET_LOCAL_TIME_MACROS_SVH
`define UTC_TO_CET_LOCAL_TIME_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define U2C_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define U2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/u2c_pkg.sv
// shared widths, calendar constants and lookup functions for the local time converter
// no dependencies; used by the channel interfaces and the top level
package u2c_pkg;

  // field widths of the channels
  localparam int UTC_W   = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // pipeline depth and internal widths
  localparam int STAGES = 11;
  localparam int DCNT_W = 16;  // day counts
  localparam int SOD_W  = 17;  // seconds of day
  localparam int DOY_W  = 9;   // day of march-based year
  localparam int CYC_W  = 6;   // four-year cycle index
  localparam int ROC_W  = 11;  // day within the four-year cycle
  localparam int REM_W  = 12;  // seconds within an hour
  localparam int WQ_W   = 13;  // week quotient

  // seconds to days: (utc >> 7) * DAY_RECIP >> DAY_SHIFT equals utc / 86400
  localparam logic [25:0]       DAY_RECIP    = 26'd50903317;
  localparam int                DAY_SHIFT    = 35;
  localparam logic [16:0]       SECS_PER_DAY = 17'd86400;

  // day count origin moved to 1968-03-01, with a padding day for the missing 2100-02-29
  localparam logic [DCNT_W-1:0] EPOCH_OFFSET = 16'd671;
  localparam logic [DCNT_W-1:0] NO_LEAP_DAY  = 16'd47541;  // 2100-03-01, days since 1970
  localparam logic [DCNT_W-1:0] NO_LEAP_PAD  = 16'd48213;  // 2100-03-01, padded count

  // four-year cycles
  localparam logic [ROC_W-1:0]  CYC_DAYS   = 11'd1461;
  localparam logic [16:0]       CYC_RECIP  = 17'd91868;
  localparam int                CYC_SHIFT  = 27;
  localparam logic [ROC_W-1:0]  YEAR1_DAYS = 11'd365;
  localparam logic [ROC_W-1:0]  YEAR2_DAYS = 11'd730;
  localparam logic [ROC_W-1:0]  YEAR3_DAYS = 11'd1095;
  localparam logic [1:0]        LEAP_YOE   = 2'd3;

  // seconds to hours and minutes
  localparam logic [13:0]       HOUR_RECIP    = 14'd9321;  // on sod >> 4
  localparam int                HOUR_SHIFT    = 21;
  localparam logic [REM_W-1:0]  SECS_PER_HOUR = 12'd3600;
  localparam logic [10:0]       MIN_RECIP     = 11'd1093;  // on rem >> 2
  localparam int                MIN_SHIFT     = 14;
  localparam logic [SEC_W-1:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;

  // weekday of a padded-free day count z: (z + 5) mod 7, 0 is sunday
  localparam logic [16:0]       WEEK_RECIP   = 17'd74899;
  localparam int                WEEK_SHIFT   = 19;
  localparam logic [2:0]        DAYS_PER_WK  = 3'd7;
  localparam logic [DCNT_W-1:0] WEEKDAY_BIAS = 16'd5;
  localparam logic [2:0]        OCT_WD_STEP  = 3'd4;  // 214 days between the two 31sts

  // day offsets within a march-based year
  localparam logic [DOY_W-1:0]  MAR31_DOY = 9'd30;
  localparam logic [DOY_W-1:0]  OCT31_DOY = 9'd244;
  localparam logic [DOY_W-1:0]  JAN1_DOY  = 9'd306;
  localparam logic [3:0]        MP_JAN    = 4'd10;

  // years
  localparam logic [YEAR_W-1:0] YEAR_BASE    = 12'd1968;
  localparam logic [YEAR_W-1:0] VALID_FIRST  = 12'd2000;
  localparam logic [YEAR_W-1:0] VALID_LAST   = 12'd2099;
  localparam logic [YEAR_W-1:0] NO_LEAP_YEAR = 12'd2100;

  // month codes
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // first day of each month in a march-based year, march is index 0
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // days in a calendar month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] res;
    unique case (month) inside
      MON_FEB:                          res = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: res = 5'd30;
      default:                          res = 5'd31;
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/u2c_if.sv
// valid/ready channel interfaces for the timestamp input and the local time result
// depends on u2c_pkg for the field widths
interface u2c_in_if
  import u2c_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [UTC_W-1:0] utc_seconds;

  modport source (output valid, output utc_seconds, input ready);
  modport sink (input valid, input utc_seconds, output ready);
endinterface

interface u2c_out_if
  import u2c_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  local_year;
  logic [MONTH_W-1:0] local_month;
  logic [DAY_W-1:0]   local_day;
  logic [HOUR_W-1:0]  local_hour;
  logic [MIN_W-1:0]   local_minute;
  logic [SEC_W-1:0]   local_second;
  logic               summer_time;
  logic               date_valid;

  modport source (output valid, output local_year, output local_month, output local_day,
                  output local_hour, output local_minute, output local_second,
                  output summer_time, output date_valid, input ready);
  modport sink (input valid, input local_year, input local_month, input local_day,
                input local_hour, input local_minute, input local_second,
                input summer_time, input date_valid, output ready);
endinterface

// File: hw/rtl/utc_to_cet_local_time.sv
// utc timestamp to cet/cest local date and time; uses u2c_pkg, u2c_if and the macros header
// throughput: one beat per cycle while the result channel is ready; each stage stalls only
// when it and all stages after it are full and the result is not taken, so bubbles close
// up and the input takes a beat while a result waits
// reset: synchronous, clears the stage valid bits only; no clearing pass
`include "utc_to_cet_local_time_macros.svh"

module utc_to_cet_local_time
  import u2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  u2c_in_if.sink      in_ch,
  u2c_out_if.source   out_ch
);

  // stage valid bits and load enables
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES:0]   ld_w;
  logic              in_acc;
  logic              out_acc;

  always_comb begin
    ld_w[STAGES] = out_ch.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ld_w[k] = !vld_r[k] || ld_w[k + 1];
    end
  end

  always_comb begin
    vld_nxt[0] = ld_w[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_nxt[k] = ld_w[k] ? vld_r[k - 1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = ld_w[0];
  assign in_acc      = in_ch.valid && ld_w[0];
  assign out_acc     = vld_r[STAGES-1] && out_ch.ready;

  // stage 1: day count by reciprocal multiply
  logic [50:0]        day_prod;
  logic [DCNT_W-1:0]  s1_days_nxt;
  logic [UTC_W-1:0]   s1_utc_r;
  logic [DCNT_W-1:0]  s1_days_r;

  always_comb begin
    day_prod    = 51'(in_ch.utc_seconds[UTC_W-1:7]) * 51'(DAY_RECIP);
    s1_days_nxt = day_prod[50:DAY_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (ld_w[0]) begin
      s1_utc_r  <= in_ch.utc_seconds;
      s1_days_r <= s1_days_nxt;
    end
  end

  // stage 2: seconds of day, padded day count from 1968-03-01
  logic [32:0]        day_secs;
  logic [UTC_W-1:0]   sod_full;
  logic [SOD_W-1:0]   s2_sod_nxt;
  logic [DCNT_W-1:0]  s2_zz_nxt;
  logic [SOD_W-1:0]   s2_sod_r;
  logic [DCNT_W-1:0]  s2_zz_r;

  always_comb begin
    day_secs   = 33'(s1_days_r) * 33'(SECS_PER_DAY);
    sod_full   = s1_utc_r - day_secs[UTC_W-1:0];
    s2_sod_nxt = sod_full[SOD_W-1:0];
    s2_zz_nxt  = s1_days_r + EPOCH_OFFSET
               + DCNT_W'(s1_days_r >= NO_LEAP_DAY);
  end

  always_ff @(posedge clk) begin
    if (ld_w[1]) begin
      s2_sod_r <= s2_sod_nxt;
      s2_zz_r  <= s2_zz_nxt;
    end
  end

  // stage 3: four-year cycle and utc hour by reciprocal multiplies
  logic [32:0]        cyc_prod;
  logic [26:0]        hr_prod;
  logic [CYC_W-1:0]   s3_cyc_nxt;
  logic [HOUR_W-1:0]  s3_hour_nxt;
  logic [CYC_W-1:0]   s3_cyc_r;
  logic [DCNT_W-1:0]  s3_zz_r;
  logic [SOD_W-1:0]   s3_sod_r;
  logic [HOUR_W-1:0]  s3_hour_r;

  always_comb begin
    cyc_prod    = 33'(s2_zz_r) * 33'(CYC_RECIP);
    s3_cyc_nxt  = cyc_prod[CYC_SHIFT+CYC_W-1:CYC_SHIFT];
    hr_prod     = 27'(s2_sod_r[SOD_W-1:4]) * 27'(HOUR_RECIP);
    s3_hour_nxt = hr_prod[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (ld_w[2]) begin
      s3_cyc_r  <= s3_cyc_nxt;
      s3_zz_r   <= s2_zz_r;
      s3_sod_r  <= s2_sod_r;
      s3_hour_r <= s3_hour_nxt;
    end
  end

  // stage 4: day within cycle, seconds within hour
  logic [16:0]        cyc_days;
  logic [DCNT_W-1:0]  roc_full;
  logic [16:0]        hr_secs;
  logic [SOD_W-1:0]   rem_full;
  logic [ROC_W-1:0]   s4_roc_r;
  logic [REM_W-1:0]   s4_rem_r;
  logic [CYC_W-1:0]   s4_cyc_r;
  logic [DCNT_W-1:0]  s4_zz_r;
  logic [HOUR_W-1:0]  s4_hour_r;

  always_comb begin
    cyc_days = 17'(s3_cyc_r) * 17'(CYC_DAYS);
    roc_full = s3_zz_r - cyc_days[DCNT_W-1:0];
    hr_secs  = 17'(s3_hour_r) * 17'(SECS_PER_HOUR);
    rem_full = s3_sod_r - hr_secs;
  end

  always_ff @(posedge clk) begin
    if (ld_w[3]) begin
      s4_roc_r  <= roc_full[ROC_W-1:0];
      s4_rem_r  <= rem_full[REM_W-1:0];
      s4_cyc_r  <= s3_cyc_r;
      s4_zz_r   <= s3_zz_r;
      s4_hour_r <= s3_hour_r;
    end
  end

  // stage 5: year within cycle, day of march-based year, minute
  logic [1:0]         yoe_w;
  logic [ROC_W-1:0]   yoe_days;
  logic [ROC_W-1:0]   doy_full;
  logic [20:0]        min_prod;
  logic [1:0]         s5_yoe_r;
  logic [DOY_W-1:0]   s5_doy_r;
  logic [MIN_W-1:0]   s5_min_r;
  logic [REM_W-1:0]   s5_rem_r;
  logic [CYC_W-1:0]   s5_cyc_r;
  logic [DCNT_W-1:0]  s5_zz_r;
  logic [HOUR_W-1:0]  s5_hour_r;

  always_comb begin
    if (s4_roc_r >= YEAR3_DAYS) begin
      yoe_w    = 2'd3;
      yoe_days = YEAR3_DAYS;
    end else if (s4_roc_r >= YEAR2_DAYS) begin
      yoe_w    = 2'd2;
      yoe_days = YEAR2_DAYS;
    end else if (s4_roc_r >= YEAR1_DAYS) begin
      yoe_w    = 2'd1;
      yoe_days = YEAR1_DAYS;
    end else begin
      yoe_w    = 2'd0;
      yoe_days = '0;
    end
    doy_full = s4_roc_r - yoe_days;
    min_prod = 21'(s4_rem_r[REM_W-1:2]) * 21'(MIN_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ld_w[4]) begin
      s5_yoe_r  <= yoe_w;
      s5_doy_r  <= doy_full[DOY_W-1:0];
      s5_min_r  <= min_prod[MIN_SHIFT+MIN_W-1:MIN_SHIFT];
      s5_rem_r  <= s4_rem_r;
      s5_cyc_r  <= s4_cyc_r;
      s5_zz_r   <= s4_zz_r;
      s5_hour_r <= s4_hour_r;
    end
  end

  // stage 6: month index and day of month, march 1st of the calendar year, second
  logic [3:0]         mp_w;
  logic [DOY_W-1:0]   dom_full;
  logic               jf_w;
  logic [DOY_W-1:0]   ylen_w;
  logic [DCNT_W-1:0]  m1_w;
  logic [11:0]        min_secs;
  logic [REM_W-1:0]   sec_full;
  logic [3:0]         s6_mp_r;
  logic [DAY_W-1:0]   s6_day_r;
  logic               s6_jf_r;
  logic [DCNT_W-1:0]  s6_m1_r;
  logic [SEC_W-1:0]   s6_sec_r;
  logic [MIN_W-1:0]   s6_min_r;
  logic [CYC_W-1:0]   s6_cyc_r;
  logic [1:0]         s6_yoe_r;
  logic [DCNT_W-1:0]  s6_zz_r;
  logic [HOUR_W-1:0]  s6_hour_r;

  always_comb begin
    mp_w = '0;
    for (int k = 1; k < 12; k++) begin
      mp_w = mp_w + 4'(s5_doy_r >= month_start(4'(k)));
    end
    dom_full = s5_doy_r - month_start(mp_w) + 9'd1;
    jf_w     = s5_doy_r >= JAN1_DOY;
    ylen_w   = (s5_yoe_r == LEAP_YOE) ? 9'd366 : 9'd365;
    // following march when the date falls in january or february
    m1_w     = s5_zz_r - DCNT_W'(s5_doy_r) + (jf_w ? DCNT_W'(ylen_w) : '0);
    min_secs = 12'(s5_min_r) * 12'(SECS_PER_MIN);
    sec_full = s5_rem_r - min_secs;
  end

  always_ff @(posedge clk) begin
    if (ld_w[5]) begin
      s6_mp_r   <= mp_w;
      s6_day_r  <= dom_full[DAY_W-1:0];
      s6_jf_r   <= jf_w;
      s6_m1_r   <= m1_w;
      s6_sec_r  <= sec_full[SEC_W-1:0];
      s6_min_r  <= s5_min_r;
      s6_cyc_r  <= s5_cyc_r;
      s6_yoe_r  <= s5_yoe_r;
      s6_zz_r   <= s5_zz_r;
      s6_hour_r <= s5_hour_r;
    end
  end

  // stage 7: calendar month and year, march and october 31st in true day counts
  logic [MONTH_W-1:0] month_w;
  logic [YEAR_W-1:0]  year_w;
  logic [DCNT_W-1:0]  pad_adj;
  logic [DCNT_W-1:0]  s7_m31_nxt;
  logic [DCNT_W-1:0]  s7_o31_nxt;
  logic [DCNT_W-1:0]  s7_zr_nxt;
  logic [YEAR_W-1:0]  s7_year_r;
  logic [MONTH_W-1:0] s7_month_r;
  logic [DAY_W-1:0]   s7_day_r;
  logic [DCNT_W-1:0]  s7_m31_r;
  logic [DCNT_W-1:0]  s7_o31_r;
  logic [DCNT_W-1:0]  s7_zr_r;
  logic [HOUR_W-1:0]  s7_hour_r;
  logic [MIN_W-1:0]   s7_min_r;
  logic [SEC_W-1:0]   s7_sec_r;

  always_comb begin
    month_w    = (s6_mp_r < MP_JAN) ? (s6_mp_r + MON_MAR) : (s6_mp_r - (MP_JAN - MON_JAN));
    year_w     = YEAR_BASE + YEAR_W'({s6_cyc_r, 2'b00}) + YEAR_W'(s6_yoe_r)
               + YEAR_W'(s6_jf_r);
    pad_adj    = DCNT_W'(s6_m1_r >= NO_LEAP_PAD);
    s7_m31_nxt = s6_m1_r + DCNT_W'(MAR31_DOY) - pad_adj;
    s7_o31_nxt = s6_m1_r + DCNT_W'(OCT31_DOY) - pad_adj;
    s7_zr_nxt  = s6_zz_r - DCNT_W'(s6_zz_r >= NO_LEAP_PAD);
  end

  always_ff @(posedge clk) begin
    if (ld_w[6]) begin
      s7_year_r  <= year_w;
      s7_month_r <= month_w;
      s7_day_r   <= s6_day_r;
      s7_m31_r   <= s7_m31_nxt;
      s7_o31_r   <= s7_o31_nxt;
      s7_zr_r    <= s7_zr_nxt;
      s7_hour_r  <= s6_hour_r;
      s7_min_r   <= s6_min_r;
      s7_sec_r   <= s6_sec_r;
    end
  end

  // stage 8: weekday quotient of march 31st
  logic [DCNT_W-1:0]  warg_w;
  logic [32:0]        wk_prod;
  logic [DCNT_W-1:0]  s8_warg_r;
  logic [WQ_W-1:0]    s8_wq_r;
  logic [DCNT_W-1:0]  s8_m31_r;
  logic [DCNT_W-1:0]  s8_o31_r;
  logic [DCNT_W-1:0]  s8_zr_r;
  logic [YEAR_W-1:0]  s8_year_r;
  logic [MONTH_W-1:0] s8_month_r;
  logic [DAY_W-1:0]   s8_day_r;
  logic [HOUR_W-1:0]  s8_hour_r;
  logic [MIN_W-1:0]   s8_min_r;
  logic [SEC_W-1:0]   s8_sec_r;

  always_comb begin
    warg_w  = s7_m31_r + WEEKDAY_BIAS;
    wk_prod = 33'(warg_w) * 33'(WEEK_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ld_w[7]) begin
      s8_warg_r  <= warg_w;
      s8_wq_r    <= wk_prod[WEEK_SHIFT+WQ_W-1:WEEK_SHIFT];
      s8_m31_r   <= s7_m31_r;
      s8_o31_r   <= s7_o31_r;
      s8_zr_r    <= s7_zr_r;
      s8_year_r  <= s7_year_r;
      s8_month_r <= s7_month_r;
      s8_day_r   <= s7_day_r;
      s8_hour_r  <= s7_hour_r;
      s8_min_r   <= s7_min_r;
      s8_sec_r   <= s7_sec_r;
    end
  end

  // stage 9: last sundays of march and october
  logic [DCNT_W-1:0]  wq7;
  logic [DCNT_W-1:0]  wrem;
  logic [2:0]         wd_mar;
  logic [2:0]         wd_oct;
  logic [DCNT_W-1:0]  s9_start_r;
  logic [DCNT_W-1:0]  s9_end_r;
  logic [DCNT_W-1:0]  s9_zr_r;
  logic [YEAR_W-1:0]  s9_year_r;
  logic [MONTH_W-1:0] s9_month_r;
  logic [DAY_W-1:0]   s9_day_r;
  logic [HOUR_W-1:0]  s9_hour_r;
  logic [MIN_W-1:0]   s9_min_r;
  logic [SEC_W-1:0]   s9_sec_r;

  always_comb begin
    wq7    = DCNT_W'(s8_wq_r) * DCNT_W'(DAYS_PER_WK);
    wrem   = s8_warg_r - wq7;
    wd_mar = wrem[2:0];
    wd_oct = (wd_mar >= (DAYS_PER_WK - OCT_WD_STEP)) ? (wd_mar - (DAYS_PER_WK - OCT_WD_STEP))
                                                      : (wd_mar + OCT_WD_STEP);
  end

  always_ff @(posedge clk) begin
    if (ld_w[8]) begin
      s9_start_r <= s8_m31_r - DCNT_W'(wd_mar);
      s9_end_r   <= s8_o31_r - DCNT_W'(wd_oct);
      s9_zr_r    <= s8_zr_r;
      s9_year_r  <= s8_year_r;
      s9_month_r <= s8_month_r;
      s9_day_r   <= s8_day_r;
      s9_hour_r  <= s8_hour_r;
      s9_min_r   <= s8_min_r;
      s9_sec_r   <= s8_sec_r;
    end
  end

  // stage 10: summer decision, local hour with day carry, month and year end flags
  logic               after_start;
  logic               before_end;
  logic               summer_w;
  logic [HOUR_W-1:0]  lh_raw;
  logic               carry_w;
  logic [HOUR_W-1:0]  lhour_w;
  logic               leap_w;
  logic               eom_w;
  logic [YEAR_W-1:0]  year_inc;
  logic [YEAR_W-1:0]  s10_year_r;
  logic [MONTH_W-1:0] s10_month_r;
  logic [DAY_W-1:0]   s10_day_r;
  logic [HOUR_W-1:0]  s10_hour_r;
  logic [MIN_W-1:0]   s10_min_r;
  logic [SEC_W-1:0]   s10_sec_r;
  logic               s10_summer_r;
  logic               s10_carry_r;
  logic               s10_eom_r;
  logic               s10_eoy_r;
  logic               s10_vs_r;
  logic               s10_vn_r;

  always_comb begin
    // switch instants fall at 01:00 utc on the sunday
    after_start = (s9_zr_r > s9_start_r) || ((s9_zr_r == s9_start_r) && (s9_hour_r != '0));
    before_end  = (s9_zr_r < s9_end_r) || ((s9_zr_r == s9_end_r) && (s9_hour_r == '0));
    summer_w    = after_start && before_end;
    lh_raw      = s9_hour_r + 5'd1 + HOUR_W'(summer_w);
    carry_w     = lh_raw >= HOURS_PER_DAY;
    lhour_w     = carry_w ? (lh_raw - HOURS_PER_DAY) : lh_raw;
    leap_w      = (s9_year_r[1:0] == 2'b00) && (s9_year_r != NO_LEAP_YEAR);
    eom_w       = s9_day_r == month_len(s9_month_r, leap_w);
    year_inc    = s9_year_r + 12'd1;
  end

  always_ff @(posedge clk) begin
    if (ld_w[9]) begin
      s10_year_r   <= s9_year_r;
      s10_month_r  <= s9_month_r;
      s10_day_r    <= s9_day_r;
      s10_hour_r   <= lhour_w;
      s10_min_r    <= s9_min_r;
      s10_sec_r    <= s9_sec_r;
      s10_summer_r <= summer_w;
      s10_carry_r  <= carry_w;
      s10_eom_r    <= eom_w;
      s10_eoy_r    <= eom_w && (s9_month_r == MON_DEC);
      s10_vs_r     <= (s9_year_r >= VALID_FIRST) && (s9_year_r <= VALID_LAST);
      s10_vn_r     <= (year_inc >= VALID_FIRST) && (year_inc <= VALID_LAST);
    end
  end

  // stage 11: roll the date over on a day carry, output register
  logic [YEAR_W-1:0]  year_out;
  logic [MONTH_W-1:0] month_out;
  logic [DAY_W-1:0]   day_out;
  logic               valid_out;
  logic [YEAR_W-1:0]  s11_year_r;
  logic [MONTH_W-1:0] s11_month_r;
  logic [DAY_W-1:0]   s11_day_r;
  logic [HOUR_W-1:0]  s11_hour_r;
  logic [MIN_W-1:0]   s11_min_r;
  logic [SEC_W-1:0]   s11_sec_r;
  logic               s11_summer_r;
  logic               s11_dvalid_r;

  always_comb begin
    year_out  = s10_year_r;
    month_out = s10_month_r;
    day_out   = s10_day_r;
    valid_out = s10_vs_r;
    if (s10_carry_r) begin
      if (s10_eom_r) begin
        day_out = 5'd1;
        if (s10_eoy_r) begin
          month_out = MON_JAN;
          year_out  = s10_year_r + 12'd1;
          valid_out = s10_vn_r;
        end else begin
          month_out = s10_month_r + 4'd1;
        end
      end else begin
        day_out = s10_day_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_w[10]) begin
      s11_year_r   <= year_out;
      s11_month_r  <= month_out;
      s11_day_r    <= day_out;
      s11_hour_r   <= s10_hour_r;
      s11_min_r    <= s10_min_r;
      s11_sec_r    <= s10_sec_r;
      s11_summer_r <= s10_summer_r;
      s11_dvalid_r <= valid_out;
    end
  end

  // result channel
  assign out_ch.valid        = vld_r[STAGES-1];
  assign out_ch.local_year   = s11_year_r;
  assign out_ch.local_month  = s11_month_r;
  assign out_ch.local_day    = s11_day_r;
  assign out_ch.local_hour   = s11_hour_r;
  assign out_ch.local_minute = s11_min_r;
  assign out_ch.local_second = s11_sec_r;
  assign out_ch.summer_time  = s11_summer_r;
  assign out_ch.date_valid   = s11_dvalid_r;

  // checks on the pipeline bookkeeping and the result ranges
  `U2C_ASSERT_NEXT(a_occupancy, 1'b1, $countones(vld_r) == $past($countones(vld_r)) + $past(in_acc) - $past(out_acc), "stage valid count lost or gained a beat")
  `U2C_ASSERT_NOW(a_full_when_blocked, !in_ch.ready, &vld_r, "input blocked with a bubble in the pipeline")
  `U2C_ASSERT_NOW(a_time_range, out_ch.valid, (out_ch.local_hour < HOURS_PER_DAY) && (out_ch.local_minute < SECS_PER_MIN) && (out_ch.local_second < SECS_PER_MIN), "local time of day out of range")
  `U2C_ASSERT_NOW(a_summer_months, out_ch.valid && out_ch.summer_time, (out_ch.local_month >= MON_MAR) && (out_ch.local_month <= MON_OCT), "summer time outside march to october")

endmodule

// File: tb/tb_top.sv
// self-checking bench for the utc to cet/cest local time converter, top module tb_top
// depends on u2c_pkg, the u2c_in_if/u2c_out_if channels and utc_to_cet_local_time
module tb_top;
  import u2c_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // calendar arithmetic
  localparam longint DAY_SECS   = 86400;
  localparam longint HOUR_SECS  = 3600;
  localparam longint CET_SHIFT  = 3600;
  localparam longint CEST_SHIFT = 7200;
  localparam longint SWITCH_UTC = 3600;  // both switches happen at 01:00 utc
  localparam longint DAYS_SHIFT = 719468;
  localparam longint ERA_DAYS   = 146097;

  // run shape
  localparam int ITEM_COUNT = 450;
  localparam int PHASE_LEN  = 150;
  localparam int QUIET_MAX  = 4000;

  typedef struct packed {
    logic [YEAR_W-1:0]  local_year;
    logic [MONTH_W-1:0] local_month;
    logic [DAY_W-1:0]   local_day;
    logic [HOUR_W-1:0]  local_hour;
    logic [MIN_W-1:0]   local_minute;
    logic [SEC_W-1:0]   local_second;
    logic               summer_time;
    logic               date_valid;
  } local_time_t;

  typedef enum int {PICK_ANY, PICK_DST, PICK_NEW_YEAR, PICK_MARCH, PICK_TOP} pick_kind_e;

  // calendar model plus the queue of local times still owed by the block
  class local_time_board;
    local_time_t     expected_q[$];
    logic [UTC_W-1:0] utc_q[$];
    int errors;
    int accepted;
    int checked;
    int summer_seen;
    int invalid_seen;

    function new();
      errors = 0;
      accepted = 0;
      checked = 0;
      summer_seen = 0;
      invalid_seen = 0;
    endfunction

    // day count since 1970-01-01 to year, month, day
    function void to_date(input longint unsigned days, output longint unsigned yr,
                          output longint unsigned mo, output longint unsigned dy);
      longint unsigned z, era, doe, yoe, doy, mp;
      z   = days + DAYS_SHIFT;
      era = z / ERA_DAYS;
      doe = z - era * ERA_DAYS;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      mo  = (mp < 10) ? mp + 3 : mp - 9;
      dy  = doy - (153 * mp + 2) / 5 + 1;
      yr  = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
    endfunction

    // year, month (march onwards), day to day count since 1970-01-01
    function longint unsigned to_days(input longint unsigned yr, input longint unsigned mo,
                                      input longint unsigned dy);
      longint unsigned era, yoe, doy, doe;
      era = yr / 400;
      yoe = yr - era * 400;
      doy = (153 * (mo - 3) + 2) / 5 + dy - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * ERA_DAYS + doe - DAYS_SHIFT;
    endfunction

    // utc second of the clock change in march or october of a year
    function longint unsigned switch_instant(input longint unsigned yr,
                                             input longint unsigned mo);
      longint unsigned last;
      last = to_days(yr, mo, 31);
      return (last - (last + 4) % 7) * DAY_SECS + SWITCH_UTC;
    endfunction

    function local_time_t convert_utc(input logic [UTC_W-1:0] utc);
      longint unsigned t, lt, sod, yr, mo, dy;
      local_time_t r;
      t = utc;
      to_date(t / DAY_SECS, yr, mo, dy);
      r.summer_time = (t >= switch_instant(yr, 3)) && (t < switch_instant(yr, 10));
      lt  = t + (r.summer_time ? CEST_SHIFT : CET_SHIFT);
      sod = lt % DAY_SECS;
      to_date(lt / DAY_SECS, yr, mo, dy);
      r.local_year   = YEAR_W'(yr);
      r.local_month  = MONTH_W'(mo);
      r.local_day    = DAY_W'(dy);
      r.local_hour   = HOUR_W'(sod / HOUR_SECS);
      r.local_minute = MIN_W'((sod % HOUR_SECS) / 60);
      r.local_second = SEC_W'(sod % 60);
      r.date_valid   = (yr >= 2000) && (yr <= 2099);
      return r;
    endfunction

    function void note_input(input logic [UTC_W-1:0] utc);
      accepted++;
      utc_q.push_back(utc);
      expected_q.push_back(convert_utc(utc));
    endfunction

    function void compare_field(input string name, input logic [UTC_W-1:0] utc,
                                input longint unsigned want, input longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: mismatch on %s for utc %0d: expected %0d, actual %0d",
                 $time, name, utc, want, got);
      end
    endfunction

    function void check_result(input local_time_t got);
      local_time_t want;
      logic [UTC_W-1:0] utc;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding: expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      utc  = utc_q.pop_front();
      checked++;
      if (got.summer_time) summer_seen++;
      if (!got.date_valid) invalid_seen++;
      compare_field("local_year", utc, want.local_year, got.local_year);
      compare_field("local_month", utc, want.local_month, got.local_month);
      compare_field("local_day", utc, want.local_day, got.local_day);
      compare_field("local_hour", utc, want.local_hour, got.local_hour);
      compare_field("local_minute", utc, want.local_minute, got.local_minute);
      compare_field("local_second", utc, want.local_second, got.local_second);
      compare_field("summer_time", utc, want.summer_time, got.summer_time);
      compare_field("date_valid", utc, want.date_valid, got.date_valid);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   quiet_cycles;
  logic [UTC_W-1:0] directed_q[$];

  local_time_board board = new();

  u2c_in_if  in_if ();
  u2c_out_if out_if ();

  utc_to_cet_local_time dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure, decided on the falling edge
  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
  end

  // beat monitors and watchdog, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        board.note_input(in_if.utc_seconds);
      end
      if (out_if.valid && out_if.ready) begin
        board.check_result({out_if.local_year, out_if.local_month, out_if.local_day,
                            out_if.local_hour, out_if.local_minute, out_if.local_second,
                            out_if.summer_time, out_if.date_valid});
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, board.pending());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // clamp a signed instant into the 32-bit input range
  function automatic logic [UTC_W-1:0] clamp_utc(input longint t);
    if (t < 0) return '0;
    if (t > 32'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return UTC_W'(t);
  endfunction

  // random timestamp, mostly close to clock changes and date roll-overs
  function automatic logic [UTC_W-1:0] pick_utc();
    pick_kind_e kind;
    int         sel;
    longint     off;
    longint     base;
    longint unsigned yr;
    sel = $urandom_range(99);
    if (sel < 25) kind = PICK_ANY;
    else if (sel < 65) kind = PICK_DST;
    else if (sel < 80) kind = PICK_NEW_YEAR;
    else if (sel < 95) kind = PICK_MARCH;
    else kind = PICK_TOP;
    if ($urandom_range(3) != 0) off = longint'($urandom_range(14400)) - 7200;
    else off = longint'($urandom_range(518400)) - 259200;
    case (kind)
      PICK_ANY: begin
        return $urandom();
      end
      PICK_DST: begin
        yr   = $urandom_range(2105, 1970);
        base = longint'(board.switch_instant(yr, $urandom_range(1) ? 10 : 3));
      end
      PICK_NEW_YEAR: begin
        // local new year falls at 23:00 utc on the last day of the year before
        yr   = $urandom_range(2106, 1971);
        base = longint'((board.to_days(yr - 1, 12, 31) + 1) * DAY_SECS) - CET_SHIFT;
      end
      PICK_MARCH: begin
        yr   = $urandom_range(2105, 1970);
        base = longint'(board.to_days(yr, 3, 1) * DAY_SECS) - CET_SHIFT;
      end
      default: begin
        return 32'hFFFF_FFFF - $urandom_range(300000);
      end
    endcase
    return clamp_utc(base + off);
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_utc(input logic [UTC_W-1:0] utc);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.utc_seconds <= utc;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stimulus: directed corners, then random beats, over three idling phases
  initial begin
    logic [UTC_W-1:0] utc;
    longint unsigned  sw;
    int               years[3];
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.utc_seconds = '0;
    src_idle_pct      = 25;
    sink_idle_pct     = 69;

    // range ends, year validity edges, leap day and the missing 2100 leap day
    directed_q = {32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'd946681199, 32'd946681200, 32'd4102441199,
                  32'd4102441200, 32'd951782400, 32'd4107538800};
    // both clock changes: the last second before each switch and the switch instant itself
    years = '{1970, 2024, 2105};
    foreach (years[i]) begin
      sw = board.switch_instant(years[i], 3);
      directed_q.push_back(UTC_W'(sw - 1));
      directed_q.push_back(UTC_W'(sw));
      sw = board.switch_instant(years[i], 10);
      directed_q.push_back(UTC_W'(sw - 1));
      directed_q.push_back(UTC_W'(sw));
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int n = 0; n < ITEM_COUNT; n++) begin
      case (n / PHASE_LEN)
        0: begin
          src_idle_pct  = 25;
          sink_idle_pct = 69;
        end
        1: begin
          src_idle_pct  = 69;
          sink_idle_pct = 25;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (n < directed_q.size()) utc = directed_q[n];
      else utc = pick_utc();
      send_utc(utc);
    end
    in_if.valid <= 1'b0;

    // drain, then allow for any stray beat
    while (board.pending() != 0) @(posedge clk);
    repeat (STAGES + 5) @(posedge clk);

    $display("converted %0d timestamps, %0d results checked, %0d errors",
             board.accepted, board.checked, board.errors);
    $display("%0d results in summer time, %0d outside 2000..2099",
             board.summer_seen, board.invalid_seen);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
